// ===== rtl/ata_pio_lba48_host_sequencer_unit_assert.svh =====
// Assertion macros shared by the checker of the ATA PIO LBA48 host sequencer.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ATA_PIO_LBA48_HOST_SEQUENCER_UNIT_ASSERT_SVH
`define ATA_PIO_LBA48_HOST_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ahs_pkg.sv =====
// Shared types and constants of the ATA PIO LBA48 host sequencer.
// No dependencies; used by every module of the block but ahs_fifo.
package ahs_pkg;

  localparam int unsigned WORDS_PER_SECTOR_DEF = 256;
  localparam int unsigned QUEUE_DEPTH_DEF      = 2;
  localparam int unsigned LIMIT_W              = 20;
  localparam int unsigned S_TDATA_W            = 104;
  localparam int unsigned M_TDATA_W            = 32;
  localparam int unsigned START_SEQ_LEN        = 13;
  localparam int unsigned SETTLE_LEN           = 4;

  localparam logic [LIMIT_W-1:0] READY_LIMIT_RST = 20'd10000;
  localparam logic [LIMIT_W-1:0] FLUSH_LIMIT_RST = 20'd100000;

  // Input operations.
  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_RESP      = 2'd1;
  localparam logic [1:0] OP_HOST_WORD = 2'd2;

  // Configuration register indexes.
  localparam logic REG_READY_LIMIT = 1'b0;
  localparam logic REG_FLUSH_LIMIT = 1'b1;

  // Result kinds.
  localparam logic [2:0] KIND_BUS_WRITE = 3'd0;
  localparam logic [2:0] KIND_SETTLE    = 3'd1;
  localparam logic [2:0] KIND_BUS_READ  = 3'd2;
  localparam logic [2:0] KIND_TO_HOST   = 3'd3;
  localparam logic [2:0] KIND_WANT_WORD = 3'd4;
  localparam logic [2:0] KIND_DONE      = 3'd5;

  // Task file ports.
  localparam logic [9:0] PORT_DATA     = 10'h1F0;
  localparam logic [9:0] PORT_SECCOUNT = 10'h1F2;
  localparam logic [9:0] PORT_LBA_LO   = 10'h1F3;
  localparam logic [9:0] PORT_LBA_MID  = 10'h1F4;
  localparam logic [9:0] PORT_LBA_HI   = 10'h1F5;
  localparam logic [9:0] PORT_DRIVE    = 10'h1F6;
  localparam logic [9:0] PORT_CMD      = 10'h1F7;
  localparam logic [9:0] PORT_ALTSTAT  = 10'h3F6;

  localparam logic [7:0] DRIVE_MASTER_LBA = 8'h40;
  localparam logic [7:0] CMD_READ_EXT     = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT    = 8'h34;
  localparam logic [7:0] CMD_FLUSH        = 8'hE7;
  localparam logic [7:0] ST_BUSY          = 8'h80;
  localparam logic [7:0] ST_DRQ           = 8'h08;

  // Leading part of a job.
  typedef enum logic [2:0] {
    HEAD_NONE,
    HEAD_START,
    HEAD_SETTLE,
    HEAD_TO_HOST,
    HEAD_DATA_OUT
  } head_t;

  // Closing result of a job; every job ends with exactly one.
  typedef enum logic [1:0] {
    FIN_READ_STATUS,
    FIN_READ_DATA,
    FIN_WANT_WORD,
    FIN_DONE
  } fin_t;

  // One queued job: head results, an optional command write, then the closing result.
  typedef struct packed {
    head_t       head;
    logic [63:0] arg;       // start: {sector count, LBA}; data heads: word in [15:0]
    logic        cmd_en;
    logic [7:0]  cmd_byte;
    fin_t        fin;
    logic        outcome;
  } job_t;

endpackage

// ===== rtl/ahs_fifo.sv =====
// Small register queue between the front and back parts of the sequencer.
// Generic width and depth; no package dependency.
module ahs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ahs_front.sv =====
// Front part of the sequencer: accepts items, tracks the protocol phase and
// turns each fitting item into one job for the queue. Depends on ahs_pkg.
module ahs_front #(
  parameter int unsigned WORDS_PER_SECTOR = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic                          in_write_dir,
  input  logic [47:0]                   in_block_address,
  input  logic [15:0]                   in_sector_total,
  input  logic [15:0]                   in_read_value,
  input  logic [15:0]                   in_host_word,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [ahs_pkg::LIMIT_W-1:0]   cfg_data,
  output logic                          push,
  output ahs_pkg::job_t                 push_job,
  input  logic                          queue_full
);

  import ahs_pkg::*;

  localparam int unsigned WIDX_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
  localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS_PER_SECTOR - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DRQ,
    PH_RDATA,
    PH_WDATA,
    PH_FLUSH
  } phase_t;

  phase_t              phase, phase_next;
  logic                is_write, is_write_next;
  logic [15:0]         sectors_left, sectors_left_next;
  logic [WIDX_W-1:0]   word_index, word_index_next;
  logic [LIMIT_W-1:0]  poll_count, poll_count_next;
  logic [LIMIT_W-1:0]  ready_limit;
  logic [LIMIT_W-1:0]  flush_limit;

  logic                accept;
  logic                take;
  job_t                job;
  logic                hit;
  logic [LIMIT_W-1:0]  poll_inc;
  logic [LIMIT_W-1:0]  poll_lim;
  logic [15:0]         sectors_dec;
  logic                sector_end;
  logic                drq_tail;
  logic                flush_tail;

  assign in_ready    = !queue_full;
  assign accept      = in_valid && in_ready;
  assign poll_inc    = poll_count + LIMIT_W'(1);
  assign poll_lim    = (phase == PH_DRQ) ? ready_limit : flush_limit;
  assign sectors_dec = sectors_left - 16'd1;
  assign hit         = (phase == PH_DRQ) ? ((in_read_value[7:0] & ST_DRQ) != 8'd0)
                                         : ((in_read_value[7:0] & ST_BUSY) == 8'd0);

  always_comb begin
    phase_next        = phase;
    is_write_next     = is_write;
    sectors_left_next = sectors_left;
    word_index_next   = word_index;
    poll_count_next   = poll_count;
    take              = 1'b0;
    sector_end        = 1'b0;
    drq_tail          = 1'b0;
    flush_tail        = 1'b0;
    job               = '0;
    job.head          = HEAD_NONE;
    job.fin           = FIN_DONE;

    if (accept) begin
      priority if (in_op == OP_START && phase == PH_IDLE) begin
        take              = 1'b1;
        job.head          = HEAD_START;
        job.arg           = {in_sector_total, in_block_address};
        is_write_next     = in_write_dir;
        sectors_left_next = in_sector_total;
        word_index_next   = '0;
        if (in_sector_total == 16'd0) begin
          // A count of zero would mean 65536 sectors, so no transfer command goes out.
          if (in_write_dir) begin
            flush_tail = 1'b1;
          end else begin
            job.fin    = FIN_DONE;
            phase_next = PH_IDLE;
          end
        end else begin
          job.cmd_en   = 1'b1;
          job.cmd_byte = in_write_dir ? CMD_WRITE_EXT : CMD_READ_EXT;
          drq_tail     = 1'b1;
        end
      end else if (in_op == OP_RESP && (phase == PH_DRQ || phase == PH_FLUSH)) begin
        take = 1'b1;
        if (hit) begin
          if (phase == PH_FLUSH) begin
            job.fin    = FIN_DONE;
            phase_next = PH_IDLE;
          end else begin
            word_index_next = '0;
            if (is_write) begin
              job.fin    = FIN_WANT_WORD;
              phase_next = PH_WDATA;
            end else begin
              job.fin    = FIN_READ_DATA;
              phase_next = PH_RDATA;
            end
          end
        end else begin
          job.head        = HEAD_SETTLE;
          poll_count_next = poll_inc;
          if (poll_inc >= poll_lim) begin
            // Only a data request wait reports a timeout; the flush wait ends as success.
            job.fin     = FIN_DONE;
            job.outcome = (phase == PH_DRQ);
            phase_next  = PH_IDLE;
          end else begin
            job.fin = FIN_READ_STATUS;
          end
        end
      end else if (in_op == OP_RESP && phase == PH_RDATA) begin
        take     = 1'b1;
        job.head = HEAD_TO_HOST;
        job.arg  = {48'd0, in_read_value};
        if (word_index == WIDX_LAST) begin
          word_index_next = '0;
          sector_end      = 1'b1;
        end else begin
          word_index_next = word_index + WIDX_W'(1);
          job.fin         = FIN_READ_DATA;
        end
      end else if (in_op == OP_HOST_WORD && phase == PH_WDATA) begin
        take     = 1'b1;
        job.head = HEAD_DATA_OUT;
        job.arg  = {48'd0, in_host_word};
        if (word_index == WIDX_LAST) begin
          word_index_next = '0;
          sector_end      = 1'b1;
        end else begin
          word_index_next = word_index + WIDX_W'(1);
          job.fin         = FIN_WANT_WORD;
        end
      end else begin
        take = 1'b0;
      end
    end

    if (sector_end) begin
      sectors_left_next = sectors_dec;
      if (sectors_dec != 16'd0) begin
        drq_tail = 1'b1;
      end else if (is_write) begin
        flush_tail = 1'b1;
      end else begin
        job.fin    = FIN_DONE;
        phase_next = PH_IDLE;
      end
    end

    if (drq_tail) begin
      poll_count_next = '0;
      if (ready_limit == '0) begin
        job.fin     = FIN_DONE;
        job.outcome = 1'b1;
        phase_next  = PH_IDLE;
      end else begin
        job.fin    = FIN_READ_STATUS;
        phase_next = PH_DRQ;
      end
    end

    if (flush_tail) begin
      job.cmd_en      = 1'b1;
      job.cmd_byte    = CMD_FLUSH;
      poll_count_next = '0;
      if (flush_limit == '0) begin
        job.fin    = FIN_DONE;
        phase_next = PH_IDLE;
      end else begin
        job.fin    = FIN_READ_STATUS;
        phase_next = PH_FLUSH;
      end
    end
  end

  assign push     = take;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      is_write     <= 1'b0;
      sectors_left <= '0;
      word_index   <= '0;
      poll_count   <= '0;
      ready_limit  <= READY_LIMIT_RST;
      flush_limit  <= FLUSH_LIMIT_RST;
    end else begin
      phase        <= phase_next;
      is_write     <= is_write_next;
      sectors_left <= sectors_left_next;
      word_index   <= word_index_next;
      poll_count   <= poll_count_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_READY_LIMIT: ready_limit <= cfg_data;
          REG_FLUSH_LIMIT: flush_limit <= cfg_data;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ahs_back.sv =====
// Back part of the sequencer: expands queued jobs into bus access results,
// one per cycle unless the output is stalled, into a registered output stage. Depends on ahs_pkg.
module ahs_back (
  input  logic          clk,
  input  logic          rst,
  input  ahs_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_kind,
  output logic [9:0]    out_port,
  output logic          out_wide,
  output logic [15:0]   out_value,
  output logic          out_outcome,
  output logic          out_last
);

  import ahs_pkg::*;

  typedef enum logic [1:0] {
    ST_HEAD,
    ST_CMD,
    ST_FINAL
  } stage_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  port;
    logic        wide;
    logic [15:0] value;
    logic        outcome;
    logic        last;
  } item_t;

  stage_t      stage, stage_next, eff_stage;
  logic [3:0]  step, step_next;
  logic [3:0]  head_last;
  item_t       item;
  logic        load;

  assign load = job_valid && (!out_valid || out_ready);

  // A job without a head starts directly at its command or closing result.
  always_comb begin
    if (stage == ST_HEAD && job.head == HEAD_NONE) begin
      eff_stage = job.cmd_en ? ST_CMD : ST_FINAL;
    end else begin
      eff_stage = stage;
    end
  end

  always_comb begin
    unique case (job.head)
      HEAD_START:  head_last = 4'(START_SEQ_LEN - 1);
      HEAD_SETTLE: head_last = 4'(SETTLE_LEN - 1);
      default:     head_last = 4'd0;
    endcase
  end

  always_comb begin
    item      = '0;
    item.kind = KIND_BUS_WRITE;
    unique case (eff_stage)
      ST_HEAD: begin
        unique case (job.head)
          HEAD_START: begin
            unique case (step)
              4'd0: begin
                item.port  = PORT_DRIVE;
                item.value = {8'd0, DRIVE_MASTER_LBA};
              end
              4'd1, 4'd2, 4'd3, 4'd4: begin
                item.kind = KIND_SETTLE;
                item.port = PORT_ALTSTAT;
              end
              4'd5: begin
                item.port  = PORT_SECCOUNT;
                item.value = {8'd0, job.arg[63:56]};
              end
              4'd6: begin
                item.port  = PORT_LBA_LO;
                item.value = {8'd0, job.arg[31:24]};
              end
              4'd7: begin
                item.port  = PORT_LBA_MID;
                item.value = {8'd0, job.arg[39:32]};
              end
              4'd8: begin
                item.port  = PORT_LBA_HI;
                item.value = {8'd0, job.arg[47:40]};
              end
              4'd9: begin
                item.port  = PORT_SECCOUNT;
                item.value = {8'd0, job.arg[55:48]};
              end
              4'd10: begin
                item.port  = PORT_LBA_LO;
                item.value = {8'd0, job.arg[7:0]};
              end
              4'd11: begin
                item.port  = PORT_LBA_MID;
                item.value = {8'd0, job.arg[15:8]};
              end
              4'd12: begin
                item.port  = PORT_LBA_HI;
                item.value = {8'd0, job.arg[23:16]};
              end
              default: begin
                item.port = '0;
              end
            endcase
          end
          HEAD_SETTLE: begin
            item.kind = KIND_SETTLE;
            item.port = PORT_ALTSTAT;
          end
          HEAD_TO_HOST: begin
            item.kind  = KIND_TO_HOST;
            item.value = job.arg[15:0];
          end
          HEAD_DATA_OUT: begin
            item.port  = PORT_DATA;
            item.wide  = 1'b1;
            item.value = job.arg[15:0];
          end
          default: begin
            item.kind = KIND_BUS_WRITE;
          end
        endcase
      end
      ST_CMD: begin
        item.port  = PORT_CMD;
        item.value = {8'd0, job.cmd_byte};
      end
      default: begin
        item.last = 1'b1;
        unique case (job.fin)
          FIN_READ_STATUS: begin
            item.kind = KIND_BUS_READ;
            item.port = PORT_CMD;
          end
          FIN_READ_DATA: begin
            item.kind = KIND_BUS_READ;
            item.port = PORT_DATA;
            item.wide = 1'b1;
          end
          FIN_WANT_WORD: begin
            item.kind = KIND_WANT_WORD;
          end
          FIN_DONE: begin
            item.kind    = KIND_DONE;
            item.outcome = job.outcome;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    stage_next = stage;
    step_next  = step;
    job_pop    = 1'b0;
    if (load) begin
      unique case (eff_stage)
        ST_HEAD: begin
          if (step == head_last) begin
            step_next  = 4'd0;
            stage_next = job.cmd_en ? ST_CMD : ST_FINAL;
          end else begin
            step_next = step + 4'd1;
          end
        end
        ST_CMD: begin
          stage_next = ST_FINAL;
        end
        default: begin
          stage_next = ST_HEAD;
          step_next  = 4'd0;
          job_pop    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= ST_HEAD;
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      stage <= stage_next;
      step  <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind    <= item.kind;
      out_port    <= item.port;
      out_wide    <= item.wide;
      out_value   <= item.value;
      out_outcome <= item.outcome;
      out_last    <= item.last;
    end
  end

endmodule

// ===== rtl/ata_pio_lba48_host_sequencer_unit.sv =====
// Top level of the ATA PIO LBA48 host sequencer: front, job queue and back.
// Depends on ahs_pkg, ahs_front, ahs_fifo and ahs_back.
//
//  Channel   Direction  Handshake                      Carries
//  s_axis    in         s_axis_tvalid / s_axis_tready  operation and start/data fields
//  m_axis    out        m_axis_tvalid / m_axis_tready  one bus access or status result
//  cfg       in         cfg_valid / cfg_ready          poll limit register writes
//
// The front accepts one input transfer per cycle while the job queue has room;
// every accepted item is classified in that same cycle against the phase.
// The back emits one result per cycle from its output register while the output is
// not stalled. A start item expands into 13 head results, a command write (none for
// a read of zero sectors) and a closing result; a poll, data or host word item into 1 to 5 results.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds in its register while up to QUEUE_DEPTH jobs wait.
module ata_pio_lba48_host_sequencer_unit #(
  parameter int unsigned WORDS_PER_SECTOR = ahs_pkg::WORDS_PER_SECTOR_DEF,
  parameter int unsigned QUEUE_DEPTH      = ahs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // write_dir [0], block_address [48:1], sector_total [64:49],
  // read_value [80:65], host_word [96:81], zero [103:97]
  input  logic [ahs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // port [9:0], wide [10], bus_value [26:11], outcome [27], zero [31:28]
  output logic [ahs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // kind [2:0]
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [ahs_pkg::LIMIT_W-1:0]    cfg_data
);

  import ahs_pkg::*;

  localparam int unsigned JOB_W = $bits(job_t);

  job_t         push_job;
  job_t         pop_job;
  logic         push;
  logic         queue_full;
  logic         queue_empty;
  logic         job_pop;
  logic [9:0]   out_port;
  logic         out_wide;
  logic [15:0]  out_value;
  logic         out_outcome;

  // Configuration writes are always taken; the user must write only while idle (unenforced).
  assign cfg_ready = 1'b1;

  ahs_front #(
    .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .in_op            (s_axis_tuser),
    .in_write_dir     (s_axis_tdata[0]),
    .in_block_address (s_axis_tdata[48:1]),
    .in_sector_total  (s_axis_tdata[64:49]),
    .in_read_value    (s_axis_tdata[80:65]),
    .in_host_word     (s_axis_tdata[96:81]),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .push             (push),
    .push_job         (push_job),
    .queue_full       (queue_full)
  );

  // Jobs wait here so the front keeps taking items while results drain.
  ahs_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (queue_full),
    .pop       (job_pop),
    .pop_data  (pop_job),
    .empty     (queue_empty)
  );

  ahs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (pop_job),
    .job_valid   (!queue_empty),
    .job_pop     (job_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_port    (out_port),
    .out_wide    (out_wide),
    .out_value   (out_value),
    .out_outcome (out_outcome),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_outcome, out_value, out_wide, out_port};

endmodule

// ===== rtl/ahs_checker.sv =====
// Port-level checks of the ATA PIO LBA48 host sequencer, bound to the top level.
// Depends on ahs_pkg and the assertion macro header.
`include "ata_pio_lba48_host_sequencer_unit_assert.svh"

module ahs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [ahs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input logic [1:0]                     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ahs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [2:0]                     m_axis_tuser,
  input logic                           m_axis_tlast,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           cfg_index,
  input logic [ahs_pkg::LIMIT_W-1:0]    cfg_data
);

  import ahs_pkg::*;

  // A stalled result keeps its contents until it is taken.
  `AHS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // Completion is always the closing result of its item.
  `AHS_ASSERT_NOW(a_done_last, m_axis_tvalid && m_axis_tuser == KIND_DONE, m_axis_tlast, "done result without last")

  // Host-side results carry no bus port.
  `AHS_ASSERT_NOW(a_host_no_port, m_axis_tvalid && (m_axis_tuser == KIND_TO_HOST || m_axis_tuser == KIND_WANT_WORD || m_axis_tuser == KIND_DONE), m_axis_tdata[9:0] == 10'd0, "host result with port")

  // Only a completion may report a timeout.
  `AHS_ASSERT_NOW(a_outcome_done, m_axis_tvalid && m_axis_tuser != KIND_DONE, !m_axis_tdata[27], "outcome set outside done")

endmodule

bind ata_pio_lba48_host_sequencer_unit ahs_checker u_ahs_checker (.*);
